FILE: hdl/http_chunked_body_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared property shapes, all clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication
`define HCBD_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hcbd assertion failed");

// Next-cycle implication
`define HCBD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hcbd assertion failed");

`endif

FILE: hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and character helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    // Size line limit and widths
    localparam int MAX_LINE_CHARS = 32;
    localparam int LINE_LEN_W     = 6;
    localparam int SIZE_W         = 64;

    // Result status codes
    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // Input register to parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } pipe_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_digit(input logic [7:0] c);
        hex_digit_t r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hcbd_in_stage.sv
// ----------------------------------------------------------------------------
// hcbd_in_stage
// Input register of the decoder; holds one raw body byte for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [7:0] data_byte
    input  wire logic           advance,
    output hcbd_pkg::pipe_t     pipe
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign pipe.valid = valid_reg;
    assign pipe.data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/hcbd_parse_core.sv
// ----------------------------------------------------------------------------
// hcbd_parse_core
// Framing state, size line parser and result register of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hcbd_pkg::pipe_t  pipe,
    output logic                  advance,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic [1:0]            m_tuser    // [1:0] status
);

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        HS_LEAD   = 3'd0,
        HS_ZERO   = 3'd1,
        HS_PREFIX = 3'd2,
        HS_DIGITS = 3'd3,
        HS_REST   = 3'd4,
        HS_BLANK  = 3'd5,
        HS_BAD    = 3'd6
    } hex_state_t;

    phase_t                            phase_reg, phase_next;
    hex_state_t                        hs_reg, hs_next;
    logic [hcbd_pkg::SIZE_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [hcbd_pkg::SIZE_W-1:0]       hex_value_reg, hex_value_next;
    logic [hcbd_pkg::LINE_LEN_W-1:0]   line_len_reg, line_len_next;
    logic                              finished_reg, finished_next;
    logic                              failed_reg, failed_next;
    logic                              out_valid_reg;
    logic [7:0]                        out_byte_reg;
    logic [1:0]                        out_status_reg;

    logic                              fire;
    logic                              emit;
    logic [7:0]                        emit_byte;
    logic [1:0]                        emit_status;
    logic [hcbd_pkg::LINE_LEN_W-1:0]   line_len_inc;
    logic [hcbd_pkg::SIZE_W-1:0]       bytes_dec;
    hcbd_pkg::hex_digit_t              dig;
    logic [7:0]                        c;

    // Result register free: item in the input register moves on
    assign advance = !out_valid_reg || m_tready;
    assign fire    = pipe.valid && advance;
    assign c       = pipe.data;
    assign dig     = hcbd_pkg::hex_digit(c);
    assign line_len_inc = line_len_reg + 1'b1;
    assign bytes_dec    = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    // Next state and result for one byte
    always_comb
    begin
        phase_next      = phase_reg;
        hs_next         = hs_reg;
        bytes_left_next = bytes_left_reg;
        hex_value_next  = hex_value_reg;
        line_len_next   = line_len_reg;
        finished_next   = finished_reg;
        failed_next     = failed_reg;
        emit            = 1'b0;
        emit_byte       = 8'd0;
        emit_status     = hcbd_pkg::ST_BYTE;

        if (fire && !finished_reg && !failed_reg)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (c == hcbd_pkg::CH_LF)
                    begin
                        // end of size line: act on what was parsed
                        hex_value_next = '0;
                        hs_next        = HS_LEAD;
                        line_len_next  = '0;
                        if (hs_reg == HS_BAD)
                        begin
                            failed_next = 1'b1;
                            emit        = 1'b1;
                            emit_status = hcbd_pkg::ST_ERR;
                        end
                        else if (hs_reg == HS_LEAD || hs_reg == HS_BLANK)
                        begin
                            // blank line, skipped
                        end
                        else if (hex_value_reg == '0)
                        begin
                            finished_next = 1'b1;
                            emit          = 1'b1;
                            emit_status   = hcbd_pkg::ST_END;
                        end
                        else
                        begin
                            bytes_left_next = hex_value_reg;
                            phase_next      = PH_DATA;
                        end
                    end
                    else if (line_len_reg >= hcbd_pkg::LINE_LEN_W'(hcbd_pkg::MAX_LINE_CHARS))
                    begin
                        // line too long
                        failed_next = 1'b1;
                        emit        = 1'b1;
                        emit_status = hcbd_pkg::ST_ERR;
                    end
                    else
                    begin
                        line_len_next = line_len_inc;
                        unique case (hs_reg) inside
                            HS_LEAD:
                            begin
                                if (hcbd_pkg::is_space(c))
                                begin
                                    hs_next = HS_LEAD;
                                end
                                else if (c == hcbd_pkg::CH_SEMI)
                                begin
                                    // ';' as first char of the line: blank line
                                    hs_next = (line_len_inc == hcbd_pkg::LINE_LEN_W'(1))
                                              ? HS_BLANK : HS_BAD;
                                end
                                else if (c == hcbd_pkg::CH_ZERO)
                                begin
                                    hex_value_next = '0;
                                    hs_next        = HS_ZERO;
                                end
                                else if (dig.ok)
                                begin
                                    hex_value_next = {{(hcbd_pkg::SIZE_W-4){1'b0}}, dig.val};
                                    hs_next        = HS_DIGITS;
                                end
                                else
                                begin
                                    hs_next = HS_BAD;
                                end
                            end
                            HS_ZERO, HS_PREFIX, HS_DIGITS:
                            begin
                                if (hs_reg == HS_ZERO &&
                                    (c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP))
                                begin
                                    hs_next = HS_PREFIX;
                                end
                                else if (dig.ok)
                                begin
                                    // overflow past 64 bits is an error
                                    if (hex_value_reg[hcbd_pkg::SIZE_W-1 -: 4] != 4'd0)
                                    begin
                                        hs_next = HS_BAD;
                                    end
                                    else
                                    begin
                                        hex_value_next = {hex_value_reg[hcbd_pkg::SIZE_W-5:0],
                                                          dig.val};
                                        hs_next        = HS_DIGITS;
                                    end
                                end
                                else
                                begin
                                    hs_next = HS_REST;
                                end
                            end
                            default:
                            begin
                                hs_next = hs_reg;
                            end
                        endcase
                    end
                end
                PH_DATA:
                begin
                    // payload byte passes through
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        phase_next = PH_TAIL;
                    end
                    emit      = 1'b1;
                    emit_byte = c;
                end
                default:
                begin
                    // line tail: drop through LF
                    if (c == hcbd_pkg::CH_LF)
                    begin
                        phase_next     = PH_SIZE;
                        hex_value_next = '0;
                        hs_next        = HS_LEAD;
                        line_len_next  = '0;
                    end
                end
            endcase
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            hs_reg         <= HS_LEAD;
            bytes_left_reg <= '0;
            hex_value_reg  <= '0;
            line_len_reg   <= '0;
            finished_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'd0;
            out_status_reg <= hcbd_pkg::ST_BYTE;
        end
        else
        begin
            phase_reg      <= phase_next;
            hs_reg         <= hs_next;
            bytes_left_reg <= bytes_left_next;
            hex_value_reg  <= hex_value_next;
            line_len_reg   <= line_len_next;
            finished_reg   <= finished_next;
            failed_reg     <= failed_next;
            if (advance)
            begin
                out_valid_reg <= emit;
                if (emit)
                begin
                    out_byte_reg   <= emit_byte;
                    out_status_reg <= emit_status;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

FILE: hdl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips HTTP chunked framing from a body byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one raw body byte per item on s_tdata.
//   Master stream m_*: one result item per payload byte, plus one final item
//   on end of message (status 1) or framing error (status 2); m_tdata is 0
//   for those. Framing bytes produce no item.
//   Path: an accepted byte passes the input register, then the parser and
//   the result register, which drives the m_* stream.
//   Throughput: one byte per cycle while m_tready is high or the result
//   register is empty; the input register and the result register form a
//   two-deep path, so a byte is taken while a result waits. When m_tready
//   stays low, one result and one byte are held, then s_tready drops.
//   Reset: the parser returns to the start of a size line and both
//   registers empty. After end of message or an error all later bytes are
//   accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic [1:0]       m_tuser     // [1:0] status
);

    hcbd_pkg::pipe_t pipe;
    logic            advance;

    hcbd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .pipe     (pipe)
    );

    hcbd_parse_core u_parse_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .pipe     (pipe),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: hdl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic [1:0]  m_tuser
);

    logic term_seen_reg;

    // end or error item has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tuser != hcbd_pkg::ST_BYTE)
        begin
            term_seen_reg <= 1'b1;
        end
    end

    // stalled result holds
    `HCBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // only defined status codes
    `HCBD_ASSERT_NOW(a_status_code, m_tvalid,
        m_tuser == hcbd_pkg::ST_BYTE || m_tuser == hcbd_pkg::ST_END ||
        m_tuser == hcbd_pkg::ST_ERR)

    // end and error items carry a zero byte
    `HCBD_ASSERT_NOW(a_term_zero, m_tvalid && m_tuser != hcbd_pkg::ST_BYTE, m_tdata == 8'd0)

    // nothing follows end of message or error
    `HCBD_ASSERT_NOW(a_silent_after_term, term_seen_reg, !m_tvalid)

    // input stalls only behind a waiting result
    `HCBD_ASSERT_NOW(a_in_stall, !s_tready, m_tvalid && !m_tready)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/chunked_body_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_body_checker
// Watches both streams of the chunked body decoder, decodes every accepted
// body byte on its own and compares each result item with the oldest one due.
// ----------------------------------------------------------------------------

module chunked_body_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    output int         fail_count,
    output int         pending_count
);

    typedef enum logic [1:0] {AT_SIZE_LINE, AT_PAYLOAD, AT_LINE_TAIL} body_phase_t;

    // How far the size number on the current line has got
    typedef enum logic [2:0] {
        SZ_LEAD,
        SZ_ZERO,
        SZ_PREFIX,
        SZ_DIGITS,
        SZ_REST,
        SZ_BLANK,
        SZ_BAD
    } size_scan_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
    } body_result_t;

    body_result_t due_results[$];

    body_phase_t  body_phase;
    logic [63:0]  chunk_left;
    logic [63:0]  size_acc;
    size_scan_t   size_scan;
    int unsigned  line_chars;
    bit           msg_done;
    bit           msg_bad;
    int           mismatches;

    // One line per mismatch
    task automatic report_mismatch(input string what, input body_result_t got,
                                   input body_result_t want);
        mismatches++;
        $display("[%0t] mismatch, %s: got byte %02h status %0d, want byte %02h status %0d",
                 $time, what, got.out_byte, got.status, want.out_byte, want.status);
    endtask

    function automatic bit digit_weight(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'd0;
        if (c >= "0" && c <= "9")
            nib = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            nib = 4'(c - "A" + 8'd10);
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_result(input logic [7:0] b, input logic [1:0] st);
        body_result_t r;
        r.out_byte = b;
        r.status   = st;
        due_results.insert(due_results.size(), r);
    endtask

    task automatic restart_line();
        size_acc   = 64'd0;
        size_scan  = SZ_LEAD;
        line_chars = 0;
    endtask

    // Append one hex digit; a 65th bit poisons the line
    task automatic shift_in(input logic [3:0] nib);
        if (size_acc[63:60] != 4'd0)
            size_scan = SZ_BAD;
        else
        begin
            size_acc  = {size_acc[59:0], nib};
            size_scan = SZ_DIGITS;
        end
    endtask

    // One non-LF byte of a size line, line_chars already counts it
    task automatic scan_size_char(input logic [7:0] c);
        logic [3:0] nib;
        bit         is_dig;
        is_dig = digit_weight(c, nib);
        case (size_scan) inside
            SZ_LEAD:
            begin
                if (c == hcbd_pkg::CH_SPACE ||
                    (c >= hcbd_pkg::CH_TAB && c <= hcbd_pkg::CH_CR))
                    size_scan = SZ_LEAD;
                else if (c == hcbd_pkg::CH_SEMI)
                begin
                    // only a line that opens with ';' counts as blank
                    if (line_chars == 1)
                        size_scan = SZ_BLANK;
                    else
                        size_scan = SZ_BAD;
                end
                else if (c == hcbd_pkg::CH_ZERO)
                begin
                    size_acc  = 64'd0;
                    size_scan = SZ_ZERO;
                end
                else if (is_dig)
                begin
                    size_acc  = {60'd0, nib};
                    size_scan = SZ_DIGITS;
                end
                else
                    size_scan = SZ_BAD;
            end
            SZ_ZERO:
            begin
                if (c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP)
                    size_scan = SZ_PREFIX;
                else if (is_dig)
                    shift_in(nib);
                else
                    size_scan = SZ_REST;
            end
            SZ_PREFIX, SZ_DIGITS:
            begin
                if (is_dig)
                    shift_in(nib);
                else
                    size_scan = SZ_REST;
            end
            default:
                size_scan = size_scan;
        endcase
    endtask

    // Decode one accepted body byte and queue the result it is due to give
    task automatic decode_body_byte(input logic [7:0] c);
        size_scan_t  line_end_scan;
        logic [63:0] line_size;
        if (msg_done || msg_bad)
            return;
        case (body_phase)
            AT_SIZE_LINE:
            begin
                if (c == hcbd_pkg::CH_LF)
                begin
                    line_end_scan = size_scan;
                    line_size     = size_acc;
                    restart_line();
                    if (line_end_scan == SZ_BAD)
                    begin
                        msg_bad = 1'b1;
                        queue_result(8'h00, hcbd_pkg::ST_ERR);
                    end
                    else if (line_end_scan != SZ_LEAD && line_end_scan != SZ_BLANK)
                    begin
                        if (line_size == 64'd0)
                        begin
                            msg_done = 1'b1;
                            queue_result(8'h00, hcbd_pkg::ST_END);
                        end
                        else
                        begin
                            chunk_left = line_size;
                            body_phase = AT_PAYLOAD;
                        end
                    end
                end
                else if (line_chars >= hcbd_pkg::MAX_LINE_CHARS)
                begin
                    msg_bad = 1'b1;
                    queue_result(8'h00, hcbd_pkg::ST_ERR);
                end
                else
                begin
                    line_chars++;
                    scan_size_char(c);
                end
            end
            AT_PAYLOAD:
            begin
                if (chunk_left != 64'd0)
                    chunk_left = chunk_left - 64'd1;
                if (chunk_left == 64'd0)
                    body_phase = AT_LINE_TAIL;
                queue_result(c, hcbd_pkg::ST_BYTE);
            end
            default:
            begin
                // everything up to the LF after the payload is dropped
                if (c == hcbd_pkg::CH_LF)
                begin
                    body_phase = AT_SIZE_LINE;
                    restart_line();
                end
            end
        endcase
    endtask

    // Compare an accepted result with the oldest one due, field by field
    task automatic check_result(input logic [7:0] b, input logic [1:0] st);
        body_result_t got;
        body_result_t want;
        got.out_byte = b;
        got.status   = st;
        if (due_results.size() == 0)
        begin
            want = '0;
            report_mismatch("result with none due", got, want);
            return;
        end
        want = due_results.pop_front();
        if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", got, want);
        if (got.status != want.status)
            report_mismatch("status", got, want);
    endtask

    // Results are compared before the new byte is decoded: a byte's own
    // result can never leave in the cycle it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            body_phase = AT_SIZE_LINE;
            chunk_left = 64'd0;
            restart_line();
            msg_done      = 1'b0;
            msg_bad       = 1'b0;
            mismatches    = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                decode_body_byte(s_tdata);
            fail_count    <= mismatches;
            pending_count <= due_results.size();
        end
    end

endmodule

FILE: tb/sv/http_chunked_body_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test
// Feeds the decoder a chunk-encoded body: a short hand-written opening, then
// many random well-formed chunks, and finally one randomly chosen way for the
// message to end (last chunk, bare prefix, sign, overflow, long line, junk),
// followed by bytes that must be dropped. Both streams idle at random, and
// once the result side holds off long enough to back the input up.
// ----------------------------------------------------------------------------

module http_chunked_body_decoder_test;

    localparam int STIM_BYTES     = 1120;
    localparam int BACKLOG_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int STUCK_LIMIT    = 2000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int          fail_count;
    int          pending_count;
    int unsigned results_seen;
    int unsigned stuck_cycles;

    logic [7:0] body_q[$];

    http_chunked_body_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    chunked_body_checker body_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Idle length for either side: mostly none or short, now and then long,
    // and sometimes a calm stretch with no idling at all
    function automatic int unsigned idle_len(inout int unsigned calm_left);
        int unsigned pick;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            calm_left = $urandom_range(40, 150);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return hcbd_pkg::CH_ZERO + 8'(nib);
        if ($urandom_range(0, 1) == 1)
            return "A" + 8'(nib) - 8'd10;
        return "a" + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 4))
            0:       return hcbd_pkg::CH_SPACE;
            1:       return hcbd_pkg::CH_TAB;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return hcbd_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == hcbd_pkg::CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Append one byte to the body
    task automatic add_byte(input logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Size line for n bytes, in a random but legal spelling of at most
    // MAX_LINE_CHARS bytes before its LF
    task automatic put_size_line(input int unsigned n);
        logic [7:0]  line[$];
        int unsigned digits;
        int unsigned zeros;
        int unsigned room;
        bit          with_cr;
        with_cr = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 1) * $urandom_range(1, 3))
            line.insert(line.size(), space_char());
        if ($urandom_range(0, 3) == 0)
        begin
            line.insert(line.size(), hcbd_pkg::CH_ZERO);
            line.insert(line.size(),
                        ($urandom_range(0, 1) == 1) ? hcbd_pkg::CH_X_LO : hcbd_pkg::CH_X_UP);
        end
        case ($urandom_range(0, 9)) inside
            0, 1:    zeros = $urandom_range(1, 4);
            2:       zeros = $urandom_range(5, 20);
            default: zeros = 0;
        endcase
        repeat (zeros)
            line.insert(line.size(), hcbd_pkg::CH_ZERO);
        digits = 1;
        while ((n >> (4 * digits)) != 0)
            digits++;
        for (int k = digits; k > 0; k--)
            line.insert(line.size(), hex_char(4'(n >> (4 * (k - 1)))));
        // optional extension or trailing junk after the number
        room = hcbd_pkg::MAX_LINE_CHARS - line.size() - 1;
        case ($urandom_range(0, 3))
            0:
            begin
                line.insert(line.size(), hcbd_pkg::CH_SEMI);
                repeat ($urandom_range(0, room - 1))
                    line.insert(line.size(), non_lf_byte());
            end
            1:
            begin
                line.insert(line.size(), space_char());
                repeat ($urandom_range(0, 2))
                    line.insert(line.size(), non_lf_byte());
            end
            default:
                line.insert(line.size(), hcbd_pkg::CH_SEMI);
        endcase
        if (with_cr)
            line.insert(line.size(), hcbd_pkg::CH_CR);
        foreach (line[i])
            add_byte(line[i]);
        add_byte(hcbd_pkg::CH_LF);
    endtask

    task automatic put_chunk(input int unsigned n);
        put_size_line(n);
        repeat (n)
            add_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0:
                add_byte(hcbd_pkg::CH_LF);
            1:
            begin
                repeat ($urandom_range(1, 6))
                    add_byte(non_lf_byte());
                add_byte(hcbd_pkg::CH_LF);
            end
            default:
                put_str("\015\n");
        endcase
    endtask

    // Lines that the decoder skips between chunks
    task automatic put_blank_line();
        case ($urandom_range(0, 2))
            0:
                put_str("\015\n");
            1:
            begin
                repeat ($urandom_range(1, 5))
                    add_byte(space_char());
                add_byte(hcbd_pkg::CH_LF);
            end
            default:
            begin
                add_byte(hcbd_pkg::CH_SEMI);
                repeat ($urandom_range(0, 10))
                    add_byte(non_lf_byte());
                add_byte(hcbd_pkg::CH_LF);
            end
        endcase
    endtask

    // The one line that ends the message; only one fits in a single reset
    task automatic put_message_end();
        case ($urandom_range(0, 8))
            0: put_str("0\015\n");
            1: put_str("0x\015\n");
            2: put_str("  0X;last\n");
            3: put_str("-5\015\n");
            4: put_str(" ;x\n");
            5:
            begin
                // seventeen digits with a nonzero lead: more than 64 bits
                put_str("1");
                repeat (16)
                    add_byte(hex_char(4'($urandom_range(0, 15))));
                add_byte(hcbd_pkg::CH_LF);
            end
            6:
            begin
                // one byte past the line limit fails at once
                repeat ($urandom_range(hcbd_pkg::MAX_LINE_CHARS + 1,
                                       hcbd_pkg::MAX_LINE_CHARS + 8))
                    add_byte(non_lf_byte());
                add_byte(hcbd_pkg::CH_LF);
            end
            7: put_str("g\n");
            default: put_str("0g\n");
        endcase
        // dropped by the block after end or error
        repeat ($urandom_range(0, 20))
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] b, inout int unsigned calm_left);
        int unsigned gap;
        gap = idle_len(calm_left);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Result counter for the backlog trigger
    always @(posedge clk)
    begin
        if (!rst_n)
            results_seen <= 0;
        else if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
    end

    // Watchdog on cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Result side: random stalls, plus one long hold-off
    initial
    begin
        int unsigned stall;
        int unsigned calm_left;
        bit          backlog_done;
        calm_left    = 0;
        backlog_done = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!backlog_done && results_seen >= 40)
            begin
                backlog_done = 1'b1;
                m_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge clk);
            end
            stall = idle_len(calm_left);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Reset, body stimulus and verdict
    initial
    begin
        int unsigned calm_left;
        int unsigned pick;
        calm_left    = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;

        // hand-written opening: blank lines, prefix and extension,
        // payload extremes and an LF inside the payload
        put_str("\015\n");
        put_str(";c\n");
        put_str(" \t0X2;e\015\n");
        add_byte(8'h00);
        add_byte(8'hFF);
        put_str("\015\n");
        put_str("3\n");
        add_byte(hcbd_pkg::CH_LF);
        add_byte(hcbd_pkg::CH_ZERO);
        add_byte(8'h80);
        put_str("x\n");

        // random chunks, mostly small
        while (body_q.size() < STIM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                put_blank_line();
            else if (pick < 85)
                put_chunk($urandom_range(1, 16));
            else if (pick < 98)
                put_chunk($urandom_range(17, 64));
            else
                put_chunk($urandom_range(65, 255));
        end
        put_message_end();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (body_q[i])
            send_byte(body_q[i], calm_left);
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
